// File: hdl/id3_pkg.sv
// shared types, codes and helpers for the id3v2 frame parser
package id3_pkg;

    // result word kinds
    localparam logic [2:0] KIND_TITLE  = 3'd0;
    localparam logic [2:0] KIND_ARTIST = 3'd1;
    localparam logic [2:0] KIND_ALBUM  = 3'd2;
    localparam logic [2:0] KIND_TRACK  = 3'd3;
    localparam logic [2:0] KIND_LENGTH = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;
    localparam logic [2:0] KIND_OTHER  = 3'd7;

    // finish status codes
    localparam logic [2:0] ST_ALL      = 3'd0;
    localparam logic [2:0] ST_TAGEND   = 3'd1;
    localparam logic [2:0] ST_ZEROID   = 3'd2;
    localparam logic [2:0] ST_OVERSIZE = 3'd3;
    localparam logic [2:0] ST_EOF      = 3'd4;
    localparam logic [2:0] ST_BADHDR   = 3'd5;

    // parser phases
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_TAGHDR = 3'd1;
    localparam logic [2:0] PH_FRMHDR = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // number parse steps (low three bits of the number mode)
    localparam logic [2:0] NS_WS   = 3'd0;
    localparam logic [2:0] NS_SIGN = 3'd1;
    localparam logic [2:0] NS_ZERO = 3'd2;
    localparam logic [2:0] NS_ZX   = 3'd3;
    localparam logic [2:0] NS_DEC  = 3'd4;
    localparam logic [2:0] NS_OCT  = 3'd5;
    localparam logic [2:0] NS_HEX  = 3'd6;
    localparam logic [2:0] NS_STOP = 3'd7;

    // frame ids
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_TLEN = 32'h544C_454E;

    // result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        last;
        logic        empty;
    } res_t;

    function automatic logic [2:0] id_kind(input logic [31:0] id);
        logic [2:0] k;
        case (id)
            ID_TIT2: k = KIND_TITLE;
            ID_TPE1: k = KIND_ARTIST;
            ID_TALB: k = KIND_ALBUM;
            ID_TRCK: k = KIND_TRACK;
            ID_TLEN: k = KIND_LENGTH;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/id3_num_feed.sv
// one text byte into the base-0 integer parser, with saturation and final value
module id3_num_feed
    import id3_pkg::*;
(
    input  logic [7:0]  byte_i,
    input  logic        en,
    input  logic        is_len,
    input  logic [4:0]  mode_i,
    input  logic [63:0] acc_i,
    output logic [4:0]  mode_o,
    output logic [63:0] acc_o,
    output logic [63:0] value_o
);

    localparam logic [1:0] BASE8  = 2'd0;
    localparam logic [1:0] BASE10 = 2'd1;
    localparam logic [1:0] BASE16 = 2'd2;

    logic [2:0]  step;
    logic [2:0]  sc;
    logic        neg;
    logic        ovf;
    logic        eat;
    logic        add_en;
    logic [1:0]  base;
    logic [4:0]  d;
    logic [63:0] lim;
    logic [67:0] prod;
    logic [67:0] cand;
    logic [63:0] mag;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h37);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

    always_comb begin
        step   = mode_i[2:0];
        neg    = mode_i[3];
        ovf    = mode_i[4];
        sc     = mode_i[2:0];
        eat    = 1'b0;
        add_en = 1'b0;
        base   = BASE10;
        d      = hex_val(byte_i);
        if (en && mode_i[2:0] != NS_STOP) begin
            if (byte_i == 8'h00) begin
                step = NS_STOP;
            end else begin
                if (sc == NS_WS) begin
                    if (byte_i == 8'h20 || (byte_i >= 8'h09 && byte_i <= 8'h0D)) begin
                        eat = 1'b1;
                    end else if (byte_i == 8'h2B) begin
                        eat  = 1'b1;
                        step = NS_SIGN;
                    end else if (byte_i == 8'h2D) begin
                        eat  = 1'b1;
                        neg  = 1'b1;
                        step = NS_SIGN;
                    end else begin
                        sc = NS_SIGN;
                    end
                end
                if (!eat) begin
                    case (sc)
                        NS_SIGN: begin
                            if (byte_i == 8'h30) begin
                                step = NS_ZERO;
                            end else if (byte_i >= 8'h31 && byte_i <= 8'h39) begin
                                step   = NS_DEC;
                                add_en = 1'b1;
                                base   = BASE10;
                            end else begin
                                step = NS_STOP;
                            end
                        end
                        NS_ZERO: begin
                            if (byte_i == 8'h78 || byte_i == 8'h58) begin
                                step = NS_ZX;
                            end else if (byte_i >= 8'h30 && byte_i <= 8'h37) begin
                                step   = NS_OCT;
                                add_en = 1'b1;
                                base   = BASE8;
                            end else begin
                                step = NS_STOP;
                            end
                        end
                        NS_ZX, NS_HEX: begin
                            if (!d[4]) begin
                                step   = NS_HEX;
                                add_en = 1'b1;
                                base   = BASE16;
                            end else begin
                                step = NS_STOP;
                            end
                        end
                        NS_DEC: begin
                            if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
                                add_en = 1'b1;
                                base   = BASE10;
                            end else begin
                                step = NS_STOP;
                            end
                        end
                        default: begin
                            if (byte_i >= 8'h30 && byte_i <= 8'h37) begin
                                add_en = 1'b1;
                                base   = BASE8;
                            end else begin
                                step = NS_STOP;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // limit follows the sign: one more on the negative side
    always_comb begin
        if (is_len) begin
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            lim = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        end
    end

    // acc*base + d > lim is the same test as acc > (lim - d) / base
    always_comb begin
        case (base)
            BASE8:   prod = {1'b0, acc_i, 3'b000};
            BASE16:  prod = {acc_i, 4'b0000};
            default: prod = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0};
        endcase
        cand = prod + {64'd0, d[3:0]};
    end

    logic ovf_n;

    always_comb begin
        acc_o = acc_i;
        ovf_n = ovf;
        if (add_en && !ovf) begin
            if (cand > {4'd0, lim}) begin
                ovf_n = 1'b1;
            end else begin
                acc_o = cand[63:0];
            end
        end
        mode_o  = {ovf_n, neg, step};
        mag     = ovf_n ? lim : acc_o;
        value_o = neg ? (64'd0 - mag) : mag;
    end

endmodule

// File: hdl/id3_out_fifo.sv
// small result queue: up to two words in, one word out per cycle
module id3_out_fifo
    import id3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_en,
    input  res_t       push_data [2],
    input  logic       pop,
    output res_t       head,
    output logic       head_valid,
    output logic       room
);

    res_t               mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_AW:0]     cnt_reg, cnt_next;
    logic [OQ_AW:0]     n_push;

    always_comb begin
        n_push      = (OQ_AW+1)'(push_en[0]) + (OQ_AW+1)'(push_en[1]);
        wr_ptr_next = wr_ptr_reg + n_push[OQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        cnt_next    = cnt_reg + n_push - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en[0]) begin
            mem[wr_ptr_reg] <= push_data[0];
        end
        if (push_en[1]) begin
            mem[wr_ptr_reg + OQ_AW'(1)] <= push_data[1];
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);
    assign room       = (cnt_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));

endmodule

// File: hdl/id3v2_frame_parser.sv
// id3v2.3+ tag parser: header check, frame walk, text and number extraction
// flow: a word is held in the input register on acceptance and processed when the result
//   queue has room; its results are written into the result queue, whose head drives m_
// throughput: one input word per cycle while the result queue has room; a word that yields
//   two results pushes both at once into the four-entry result queue that paces the input
// reset: synchronous active-low aresetn clears the parse state and the queue

module id3v2_frame_parser
    import id3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [3:0]  m_tuser,   // [2:0] kind, [3] field_empty
    output logic        m_tlast    // field_last
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;
    logic       in_eof_reg;
    logic       proc_fire;
    logic       room;

    // parse state
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  hc_reg, hc_next;
    logic [27:0] tr_reg, tr_next;
    logic [31:0] fid_reg, fid_next;
    logic [28:0] fsz_reg, fsz_next;
    logic [27:0] fcnt_reg, fcnt_next;
    logic [4:0]  found_reg, found_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  mode_reg, mode_next;

    // state seen by this word (start of file restarts it)
    logic [2:0]  c_ph;
    logic [3:0]  c_hc;
    logic [27:0] c_tr;
    logic [31:0] c_fid;
    logic [28:0] c_fsz;
    logic [27:0] c_fcnt;
    logic [4:0]  c_found;
    logic [63:0] c_acc;
    logic [4:0]  c_mode;
    logic [2:0]  k;

    logic        nf_en;
    logic [4:0]  nf_mode;
    logic [63:0] nf_acc;
    logic [63:0] nf_value;

    logic        fld_v;
    res_t        fld;
    logic        st_v;
    logic [2:0]  st_code;
    logic        skip;
    logic        ok;
    logic        close;
    logic        from_body;
    logic        last_b;
    logic [7:0]  b;

    logic [1:0]  push_en;
    res_t        push_data [2];
    res_t        head;
    logic        head_valid;

    assign proc_fire = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
            in_eof_reg  <= s_tlast;
        end
    end

    always_comb begin
        if (in_sof_reg) begin
            c_ph    = PH_FIRST;
            c_hc    = '0;
            c_tr    = '0;
            c_fid   = '0;
            c_fsz   = '0;
            c_fcnt  = '0;
            c_found = '0;
            c_acc   = '0;
            c_mode  = '0;
        end else begin
            c_ph    = phase_reg;
            c_hc    = hc_reg;
            c_tr    = tr_reg;
            c_fid   = fid_reg;
            c_fsz   = fsz_reg;
            c_fcnt  = fcnt_reg;
            c_found = found_reg;
            c_acc   = acc_reg;
            c_mode  = mode_reg;
        end
        k = id_kind(c_fid);
    end

    assign nf_en = (c_ph == PH_BODY) && (c_fcnt != '0)
                   && (k == KIND_TRACK || k == KIND_LENGTH);

    id3_num_feed u_num (
        .byte_i  (in_byte_reg),
        .en      (nf_en),
        .is_len  (k == KIND_LENGTH),
        .mode_i  (c_mode),
        .acc_i   (c_acc),
        .mode_o  (nf_mode),
        .acc_o   (nf_acc),
        .value_o (nf_value)
    );

    always_comb begin
        b          = in_byte_reg;
        phase_next = c_ph;
        hc_next    = c_hc;
        tr_next    = c_tr;
        fid_next   = c_fid;
        fsz_next   = c_fsz;
        fcnt_next  = c_fcnt;
        found_next = c_found;
        acc_next   = c_acc;
        mode_next  = c_mode;
        fld_v      = 1'b0;
        fld        = '0;
        st_v       = 1'b0;
        st_code    = ST_ALL;
        skip       = 1'b0;
        ok         = 1'b0;
        close      = 1'b0;
        from_body  = 1'b0;
        last_b     = 1'b0;

        // one leading 0xff is dropped
        if (phase_next == PH_FIRST) begin
            phase_next = PH_TAGHDR;
            hc_next    = '0;
            skip       = (b == 8'hFF);
        end

        if (!skip) begin
            case (phase_next)
                PH_TAGHDR: begin
                    case (hc_next)
                        4'd0:    ok = (b == 8'h49);
                        4'd1:    ok = (b == 8'h44);
                        4'd2:    ok = (b == 8'h33);
                        4'd3:    ok = (b >= 8'h03) && (b != 8'hFF);
                        4'd4:    ok = (b != 8'hFF);
                        4'd5:    ok = 1'b1;
                        default: ok = !b[7];
                    endcase
                    if (!ok) begin
                        st_v       = 1'b1;
                        st_code    = ST_BADHDR;
                        phase_next = PH_DONE;
                    end else begin
                        if (hc_next >= 4'd6) begin
                            tr_next = {tr_next[20:0], 7'd0} | {20'd0, b};
                        end
                        if (hc_next == 4'd9) begin
                            hc_next = '0;
                            if (tr_next < 28'd10) begin
                                st_v       = 1'b1;
                                st_code    = ST_TAGEND;
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_FRMHDR;
                            end
                        end else begin
                            hc_next = hc_next + 4'd1;
                        end
                    end
                end
                PH_FRMHDR: begin
                    tr_next = tr_next - 28'd1;
                    if (hc_next <= 4'd3) begin
                        fid_next = (hc_next == 4'd0) ? {24'd0, b} : {fid_next[23:0], b};
                        if (hc_next == 4'd3 && fid_next == '0) begin
                            st_v       = 1'b1;
                            st_code    = ST_ZEROID;
                            phase_next = PH_DONE;
                        end
                    end else if (hc_next <= 4'd7) begin
                        // size bytes are shifted by 7 with no masking of bit 7, up to 29 bits
                        fsz_next = (hc_next == 4'd4) ? {21'd0, b}
                                 : ({fsz_next[21:0], 7'd0} | {21'd0, b});
                        if (hc_next == 4'd7 && ({1'b0, fsz_next} + 30'd2 > {2'b00, tr_next}))
                        begin
                            st_v       = 1'b1;
                            st_code    = ST_OVERSIZE;
                            phase_next = PH_DONE;
                        end
                    end
                    if (!st_v) begin
                        if (hc_next != 4'd9) begin
                            hc_next = hc_next + 4'd1;
                        end else begin
                            hc_next   = '0;
                            fcnt_next = '0;
                            acc_next  = '0;
                            mode_next = '0;
                            if (fsz_next == '0) begin
                                close = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    tr_next   = tr_next - 28'd1;
                    last_b    = ({1'b0, c_fcnt} + 29'd1 == c_fsz);
                    from_body = 1'b1;
                    if (c_fcnt != '0) begin
                        if (k == KIND_TITLE || k == KIND_ARTIST || k == KIND_ALBUM) begin
                            if (c_mode[2:0] != NS_STOP) begin
                                fld_v = 1'b1;
                                if (b == 8'h00) begin
                                    // zero byte ends the text early
                                    fld       = '{kind: k, value: 64'd0, last: 1'b1,
                                                  empty: (c_fcnt == 28'd1)};
                                    mode_next = {2'b00, NS_STOP};
                                end else begin
                                    fld = '{kind: k, value: {56'd0, b}, last: last_b,
                                            empty: 1'b0};
                                end
                            end
                        end else if (k != KIND_OTHER) begin
                            mode_next = nf_mode;
                            acc_next  = nf_acc;
                        end
                    end
                    fcnt_next = c_fcnt + 28'd1;
                    close     = last_b;
                end
                default: ;
            endcase
        end

        if (close) begin
            if ((k == KIND_TITLE || k == KIND_ARTIST || k == KIND_ALBUM)
                && fsz_next <= 29'd1) begin
                fld_v = 1'b1;
                fld   = '{kind: k, value: 64'd0, last: 1'b1, empty: 1'b1};
            end
            if (k == KIND_TRACK || k == KIND_LENGTH) begin
                fld_v = 1'b1;
                fld   = '{kind: k, value: (from_body ? nf_value : 64'd0), last: 1'b1,
                          empty: 1'b0};
            end
            if (k != KIND_OTHER) begin
                found_next[k] = 1'b1;
            end
            if (found_next == 5'h1F) begin
                st_v       = 1'b1;
                st_code    = ST_ALL;
                phase_next = PH_DONE;
            end else if (tr_next < 28'd10) begin
                st_v       = 1'b1;
                st_code    = ST_TAGEND;
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_FRMHDR;
                hc_next    = '0;
            end
        end

        if (in_eof_reg && phase_next != PH_DONE) begin
            st_v       = 1'b1;
            st_code    = ST_EOF;
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            hc_reg    <= '0;
            tr_reg    <= '0;
            fid_reg   <= '0;
            fsz_reg   <= '0;
            fcnt_reg  <= '0;
            found_reg <= '0;
            acc_reg   <= '0;
            mode_reg  <= '0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            tr_reg    <= tr_next;
            fid_reg   <= fid_next;
            fsz_reg   <= fsz_next;
            fcnt_reg  <= fcnt_next;
            found_reg <= found_next;
            acc_reg   <= acc_next;
            mode_reg  <= mode_next;
        end
    end

    // field word goes first, status word after it
    always_comb begin
        res_t st_word;
        st_word      = '{kind: KIND_STATUS, value: {61'd0, st_code}, last: 1'b1,
                         empty: 1'b0};
        push_en[0]   = proc_fire && (fld_v || st_v);
        push_en[1]   = proc_fire && fld_v && st_v;
        push_data[0] = fld_v ? fld : st_word;
        push_data[1] = st_word;
    end

    id3_out_fifo u_oq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (push_en),
        .push_data  (push_data),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .head_valid (head_valid),
        .room       (room)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = head.value;
    assign m_tuser  = {head.empty, head.kind};
    assign m_tlast  = head.last;

    a_status_ends_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && st_v) |=> (phase_reg == PH_DONE))
        else $error("status word without parse end");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> ({1'b0, fcnt_reg} < fsz_reg))
        else $error("frame body count ran past frame size");

    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TAGHDR || phase_reg == PH_FRMHDR) |-> (hc_reg < 4'd10))
        else $error("header byte count out of range");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == KIND_STATUS) |-> (m_tlast && !m_tuser[3]))
        else $error("status word without last flag");

endmodule
